// File: rtl/swom_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swom_pkg
// Shared constants for the strided window occupancy mask block: register
// indexes and stream payload layout.
// ----------------------------------------------------------------------------
package swom_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIndexWidth = 2;
  localparam logic [CfgIndexWidth-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CfgIndexWidth-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam int unsigned CfgDataWidth = 11;

  // Reset sizes
  localparam logic [CfgDataWidth-1:0] RESET_FRAME_WIDTH  = 11'd426;
  localparam logic [CfgDataWidth-1:0] RESET_FRAME_HEIGHT = 11'd240;

  // Smallest usable frame size
  localparam int unsigned MinSize = 5;

  // Input item: pixel in the low byte
  localparam int unsigned PixelWidth = 8;

  // Result item layout inside m_tdata (last_site rides on m_tlast)
  localparam int unsigned CoordWidth  = 10;
  localparam int unsigned FeatureBit  = 0;
  localparam int unsigned ColLsb      = 1;
  localparam int unsigned RowLsb      = ColLsb + CoordWidth;
  localparam int unsigned OutUsedBits = RowLsb + CoordWidth;
  localparam int unsigned OutDataWidth = ((OutUsedBits + 7) / 8) * 8;

endpackage

`default_nettype wire

// File: rtl/swom_line_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swom_line_store
// Line store for the two rows above the current pixel: bit 1 holds the
// upper row flag, bit 0 the middle row flag. One read and one write port,
// read data registered and held while no read is issued.
// ----------------------------------------------------------------------------
module swom_line_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [1:0]    rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [1:0]    wr_data
);

  logic [1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/strided_window_occupancy_mask_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// strided_window_occupancy_mask_core
// Binary 3x3 max pool on a stride-2 grid: flags each pixel as nonzero, keeps
// the flags of the two rows above in a line store and emits one result per
// site when the lower-right pixel of its window arrives.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+---------------------------------------
//  s_*      | in  | s_tvalid / s_tready | s_tdata[7:0] pixel
//  m_*      | out | m_tvalid / m_tready | m_tdata feature,col,row; m_tlast last
//  cfg_*    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data[10:0]
//
//  One pixel per clock sustained while no site result is stalled. The line
//  store is read at the accept edge; the item then enters the read-modify-write
//  stage, which writes the flags back and loads a site result into the output
//  register when it advances. Reset clears counters, column history and
//  valids; the line store has no reset. A stalled result holds a site item
//  in the stage and the input behind it; items with no site pass while the
//  result waits.
// ----------------------------------------------------------------------------
module strided_window_occupancy_mask_core #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // pixel stream
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  input  wire logic [swom_pkg::PixelWidth-1:0]        s_tdata,   // [7:0] pixel
  // result stream
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  output logic      [swom_pkg::OutDataWidth-1:0]      m_tdata,   // [0] feature,
                                                                 // [10:1] site_col,
                                                                 // [20:11] site_row,
                                                                 // [23:21] zero
  output logic                                        m_tlast,   // last_site
  // configuration writes
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [swom_pkg::CfgIndexWidth-1:0]     cfg_index,
  input  wire logic [swom_pkg::CfgDataWidth-1:0]      cfg_data
);

  import swom_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned HW = RW + 1;
  localparam int unsigned XW = (SW > CfgDataWidth) ? SW : CfgDataWidth;
  localparam int unsigned YW = (HW > CfgDataWidth) ? HW : CfgDataWidth;

  // configuration registers
  logic [CfgDataWidth-1:0] frame_width;
  logic [CfgDataWidth-1:0] frame_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RESET_FRAME_WIDTH;
      frame_height <= RESET_FRAME_HEIGHT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped sizes
  logic [XW-1:0] width_ext;
  logic [YW-1:0] height_ext;
  logic [SW-1:0] w;
  logic [HW-1:0] h;

  always_comb begin
    width_ext  = XW'(frame_width);
    height_ext = YW'(frame_height);
    if (width_ext < XW'(MinSize)) begin
      w = SW'(MinSize);
    end else if (width_ext > XW'(MAX_WIDTH)) begin
      w = SW'(MAX_WIDTH);
    end else begin
      w = width_ext[SW-1:0];
    end
    if (height_ext < YW'(MinSize)) begin
      h = HW'(MinSize);
    end else if (height_ext > YW'(MAX_HEIGHT)) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = height_ext[HW-1:0];
    end
  end

  // position counters of the next pixel
  logic [CW-1:0] column_counter;
  logic [RW-1:0] row_counter;
  logic          accept;

  logic [SW:0] col_plus1;
  logic [SW:0] col_plus2;
  logic [HW:0] row_plus1;
  logic [HW:0] row_plus2;

  assign col_plus1 = (SW+1)'(column_counter) + (SW+1)'(1);
  assign col_plus2 = (SW+1)'(column_counter) + (SW+1)'(2);
  assign row_plus1 = (HW+1)'(row_counter) + (HW+1)'(1);
  assign row_plus2 = (HW+1)'(row_counter) + (HW+1)'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_counter <= '0;
      row_counter    <= '0;
    end else if (accept) begin
      if (col_plus1 >= (SW+1)'(w)) begin
        column_counter <= '0;
        row_counter    <= (row_plus1 >= (HW+1)'(h)) ? '0 : row_plus1[RW-1:0];
      end else begin
        column_counter <= col_plus1[CW-1:0];
      end
    end
  end

  // site decode at the lower-right pixel of a window
  logic          site_hit;
  logic          site_last;
  logic [HW-1:0] last_row;
  logic [SW-1:0] last_col;
  logic [CW-1:0] site_c;
  logic [RW-1:0] site_r;

  always_comb begin
    site_c   = column_counter - CW'(1);
    site_r   = row_counter - RW'(1);
    last_row = (h - HW'(3)) & ~HW'(1);
    last_col = (w - SW'(3)) & ~SW'(1);
    site_hit = row_counter[0] && column_counter[0]
               && (row_counter >= RW'(3)) && (column_counter >= CW'(3))
               && (row_plus2 <= (HW+1)'(h)) && (col_plus2 <= (SW+1)'(w));
    site_last = (HW'(site_r) == last_row) && (SW'(site_c) == last_col);
  end

  // stage 1: line store data returns, read-modify-write
  logic          s1_valid;
  logic          s1_hit;
  logic          s1_last;
  logic          s1_cur;
  logic [CW-1:0] s1_col;
  logic [CW-1:0] s1_site_c;
  logic [RW-1:0] s1_site_r;
  logic          s1_adv;
  logic [1:0]    line_q;
  logic [1:0]    column_or_history;
  logic [1:0]    hist_eff;
  logic          vert;
  logic          win;

  assign s1_adv   = s1_valid && (!s1_hit || !m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_adv;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hit    <= site_hit;
      s1_last   <= site_last;
      s1_cur    <= (s_tdata != '0);
      s1_col    <= column_counter;
      s1_site_c <= site_c;
      s1_site_r <= site_r;
    end
  end

  // Consecutive items never share a line store address (width is at least
  // five), so the same-cycle write and read need no forwarding.
  swom_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (column_counter),
    .rd_data (line_q),
    .wr_en   (s1_adv),
    .wr_addr (s1_col),
    .wr_data ({line_q[0], s1_cur})
  );

  // window OR: current column plus the two columns to the left
  always_comb begin
    hist_eff = (s1_col == '0) ? 2'b00 : column_or_history;
    vert     = line_q[1] | line_q[0] | s1_cur;
    win      = vert | hist_eff[0] | hist_eff[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_or_history <= 2'b00;
    end else if (s1_adv) begin
      column_or_history <= {hist_eff[0], vert};
    end
  end

  // output register
  logic [31:0]             col_wide;
  logic [31:0]             row_wide;
  logic [OutDataWidth-1:0] out_word;

  assign col_wide = 32'(s1_site_c);
  assign row_wide = 32'(s1_site_r);

  // result payload, padding bits zero
  always_comb begin
    out_word                          = '0;
    out_word[FeatureBit]              = win;
    out_word[ColLsb +: CoordWidth]    = col_wide[CoordWidth-1:0];
    out_word[RowLsb +: CoordWidth]    = row_wide[CoordWidth-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv && s1_hit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_hit) begin
      m_tdata <= out_word;
      m_tlast <= s1_last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/swom_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swom_checker
// Port-level checks for the strided window occupancy mask core, bound to
// the top level.
// ----------------------------------------------------------------------------
module swom_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                s_tvalid,
  input wire logic                                s_tready,
  input wire logic                                m_tvalid,
  input wire logic                                m_tready,
  input wire logic [swom_pkg::OutDataWidth-1:0]   m_tdata,
  input wire logic                                m_tlast
);

  import swom_pkg::*;

  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("result changed while stalled");

  // no result right out of reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // site coordinates are even and padding is zero
  a_even: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[ColLsb] && !m_tdata[RowLsb]
                  && (m_tdata[OutDataWidth-1:OutUsedBits] == '0)))
    else $error("odd site coordinate or dirty padding");

  // a new result must trace back to an accepted pixel, through stage 1 and the output register
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without a preceding pixel");

endmodule

bind strided_window_occupancy_mask_core swom_checker u_swom_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

// File: tb/strided_window_occupancy_mask_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strided_window_occupancy_mask_core_tb
// Self-checking bench for the stride-2 binary 3x3 max pool. Pixels stream in
// raster order from a queue. A behavioral line-store model predicts every
// site result. Each result is checked field by field against the oldest
// prediction. Frame sizes are changed between phases, mostly at frame
// boundaries, and twice inside a frame. Phases run under source gaps, sink
// stalls, both, and neither.
// ----------------------------------------------------------------------------
module strided_window_occupancy_mask_core_tb;
  import swom_pkg::*;

  localparam int unsigned MAX_DIM       = 1024;
  localparam int unsigned RANDOM_ITEMS  = 650;
  localparam int unsigned SETTLE_CYCLES = 8;      // pipeline is two deep
  localparam int unsigned CYCLE_LIMIT   = 600000;

  // index with no register behind it
  localparam logic [CfgIndexWidth-1:0] REG_UNMAPPED = 2'd3;

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_SRC_GAPS,
    FLOW_SINK_STALLS,
    FLOW_BOTH
  } flow_t;

  typedef struct packed {
    logic                  feature;
    logic [CoordWidth-1:0] site_col;
    logic [CoordWidth-1:0] site_row;
    logic                  last_site;
  } site_t;

  // DUT signals
  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [PixelWidth-1:0]    s_tdata = '0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OutDataWidth-1:0]  m_tdata;
  logic                     m_tlast;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0]  cfg_data = '0;

  // bench state
  flow_t                 flow = FLOW_FREE;
  logic [PixelWidth-1:0] pixel_q[$];
  site_t                 site_q[$];
  int unsigned           fail_count = 0;
  int unsigned           cycle_count = 0;

  // pooling model state
  logic [CfgDataWidth-1:0] frame_w = RESET_FRAME_WIDTH;
  logic [CfgDataWidth-1:0] frame_h = RESET_FRAME_HEIGHT;
  bit                      flags_two_up[MAX_DIM];
  bit                      flags_one_up[MAX_DIM];
  bit [1:0]                col_hist = '0;
  int unsigned             col_pos = 0;
  int unsigned             row_pos = 0;

  site_t got_site;
  site_t want_site;

  strided_window_occupancy_mask_core uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // sizes below 5 act as 5, above the maximum as the maximum
  function automatic int unsigned eff_size(logic [CfgDataWidth-1:0] v, int unsigned hi);
    if (v < MinSize) return MinSize;
    if (v > hi) return hi;
    return v;
  endfunction

  // one pixel through the line stores; queues a site when its window closes
  task automatic predict_pooled_site(input logic [PixelWidth-1:0] pix);
    int unsigned w, h;
    bit cur, up, mid, vert, win;
    site_t s;
    w = eff_size(frame_w, MAX_DIM);
    h = eff_size(frame_h, MAX_DIM);
    cur = (pix != 0);
    up = 1'b0;
    mid = 1'b0;
    if (col_pos == 0) col_hist = '0;
    if (col_pos < MAX_DIM) begin
      up  = flags_two_up[col_pos];
      mid = flags_one_up[col_pos];
    end
    vert = up | mid | cur;
    win  = vert | col_hist[0] | col_hist[1];
    // lower-right corner: odd row and column, window fully inside the frame
    if ((row_pos % 2 == 1) && (col_pos % 2 == 1) && row_pos >= 3 && col_pos >= 3 &&
        row_pos + 2 <= h && col_pos + 2 <= w) begin
      s.feature   = win;
      s.site_col  = CoordWidth'(col_pos - 1);
      s.site_row  = CoordWidth'(row_pos - 1);
      s.last_site = (row_pos - 1 == ((h - 3) & ~32'd1)) &&
                    (col_pos - 1 == ((w - 3) & ~32'd1));
      site_q = {site_q, s};
    end
    if (col_pos < MAX_DIM) begin
      flags_two_up[col_pos] = mid;
      flags_one_up[col_pos] = cur;
    end
    col_hist = {col_hist[0], vert};
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  // pixels still needed to bring the counters back to the frame origin
  function automatic int unsigned pixels_left_in_frame();
    int unsigned c, r, w, h, n;
    c = col_pos;
    r = row_pos;
    w = eff_size(frame_w, MAX_DIM);
    h = eff_size(frame_h, MAX_DIM);
    n = 0;
    if (c == 0 && r == 0) return 0;
    do begin
      n++;
      if (c + 1 >= w) begin
        c = 0;
        r = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        c++;
      end
    end while (!(c == 0 && r == 0));
    return n;
  endfunction

  function automatic bit source_gap();
    if (flow == FLOW_SRC_GAPS) return $urandom_range(0, 99) < 56;
    if (flow == FLOW_BOTH) return $urandom_range(0, 99) < 13;
    return 1'b0;
  endfunction

  function automatic bit sink_ready();
    if (flow == FLOW_SINK_STALLS) return $urandom_range(0, 99) >= 56;
    if (flow == FLOW_BOTH) return $urandom_range(0, 99) >= 13;
    return 1'b1;
  endfunction

  function automatic logic [PixelWidth-1:0] rand_pixel(int unsigned pct);
    if ($urandom_range(0, 99) < pct) return PixelWidth'($urandom_range(1, 255));
    return '0;
  endfunction

  // pixel driver; valid holds until the item is taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_pooled_site(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (pixel_q.size() != 0 && !source_gap()) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pixel_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_site.feature   = m_tdata[FeatureBit];
      got_site.site_col  = m_tdata[ColLsb +: CoordWidth];
      got_site.site_row  = m_tdata[RowLsb +: CoordWidth];
      got_site.last_site = m_tlast;
      if (site_q.size() == 0) begin
        $error("result with none pending: col %0d row %0d", got_site.site_col,
               got_site.site_row);
        fail_count++;
      end else begin
        want_site = site_q.pop_front();
        if (got_site.feature !== want_site.feature) begin
          $error("feature: expected %0d, got %0d", want_site.feature, got_site.feature);
          fail_count++;
        end
        if (got_site.site_col !== want_site.site_col) begin
          $error("site_col: expected %0d, got %0d", want_site.site_col, got_site.site_col);
          fail_count++;
        end
        if (got_site.site_row !== want_site.site_row) begin
          $error("site_row: expected %0d, got %0d", want_site.site_row, got_site.site_row);
          fail_count++;
        end
        if (got_site.last_site !== want_site.last_site) begin
          $error("last_site: expected %0d, got %0d", want_site.last_site,
                 got_site.last_site);
          fail_count++;
        end
      end
    end
    m_tready <= sink_ready();
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // register write; model follows at the accepting edge
  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_FRAME_WIDTH) frame_w = val;
    else if (idx == REG_FRAME_HEIGHT) frame_h = val;
  endtask

  // sender holds off until every site is in and the pipe has emptied
  task automatic wait_drained();
    do @(negedge clk); while (pixel_q.size() != 0 || s_tvalid || site_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_pixels(input int unsigned n, input int unsigned pct);
    for (int unsigned i = 0; i < n; i++) pixel_q = {pixel_q, rand_pixel(pct)};
  endtask

  initial begin : stimulus
    int unsigned density[6];
    int unsigned phase, sent, n, w_eff, h_eff;
    logic [CfgDataWidth-1:0] w_val, h_val;

    density = '{0, 2, 5, 10, 30, 100};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: undersized writes clamp to 5x5, stray index ignored;
    // nonzero only outside the one window, so the lone site reads zero
    write_reg(REG_FRAME_WIDTH, 11'd0);
    write_reg(REG_FRAME_HEIGHT, 11'd3);
    write_reg(REG_UNMAPPED, 11'h7FF);
    for (int unsigned i = 0; i < 25; i++) begin
      pixel_q = {pixel_q, ((i == 0 || i == 24) ? 8'd255 : 8'd0)};
    end
    wait_drained();

    // random frames of small sizes, flow mode rotating per phase
    phase = 0;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      flow  = flow_t'(phase % 4);
      w_val = CfgDataWidth'($urandom_range(5, 18));
      h_val = CfgDataWidth'($urandom_range(5, 14));
      if ($urandom_range(0, 7) == 0) w_val = CfgDataWidth'($urandom_range(0, 4));
      if ($urandom_range(0, 7) == 0) h_val = CfgDataWidth'($urandom_range(0, 4));
      write_reg(REG_FRAME_WIDTH, w_val);
      write_reg(REG_FRAME_HEIGHT, h_val);
      w_eff = eff_size(w_val, MAX_DIM);
      h_eff = eff_size(h_val, MAX_DIM);
      n = w_eff * h_eff * $urandom_range(1, 2);
      queue_pixels(n, density[$urandom_range(0, 5)]);
      sent += n;
      wait_drained();
      phase++;
    end

    // size changes inside a frame: shrink width past the column counter
    flow = FLOW_BOTH;
    write_reg(REG_FRAME_WIDTH, 11'd12);
    write_reg(REG_FRAME_HEIGHT, 11'd10);
    queue_pixels(12 * 10 + 12 * 4 + 9, 10);
    wait_drained();
    write_reg(REG_FRAME_WIDTH, 11'd6);
    write_reg(REG_FRAME_HEIGHT, 11'd7);
    queue_pixels(pixels_left_in_frame() + 6 * 6 + 2, 10);
    wait_drained();
    // then shrink height below the row counter
    write_reg(REG_FRAME_HEIGHT, 11'd5);
    queue_pixels(pixels_left_in_frame() + 60, 10);
    wait_drained();
    queue_pixels(pixels_left_in_frame(), 10);
    wait_drained();

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/swom_pkg.sv
rtl/swom_line_store.sv
rtl/strided_window_occupancy_mask_core.sv
rtl/swom_checker.sv
tb/strided_window_occupancy_mask_core_tb.sv
